FILE: hdl/tspt_pkg.sv
// Package for the tagged stack prune table: operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
package tspt_pkg;
    localparam logic [2:0] FUNC_ADD    = 3'd0;
    localparam logic [2:0] FUNC_PRUNE  = 3'd1;
    localparam logic [2:0] FUNC_CHOP   = 3'd2;
    localparam logic [2:0] FUNC_TOP    = 3'd3;
    localparam logic [2:0] FUNC_PARENT = 3'd4;
    localparam logic [2:0] FUNC_INDEX  = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_ROOT_PAR  = 3'd2;
    localparam logic [2:0] ST_NULL_PAR  = 3'd3;
    localparam logic [2:0] ST_PAR_ABS   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
endpackage

FILE: hdl/tagged_stack_prune_table_unit.sv
// Top level of the tagged stack prune table.
// Depends on tspt_pkg.
`timescale 1ns / 1ps
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall
//  out     | output    | out_valid / out_stall
//
// One transaction runs a sequencer that walks the table one entry per cycle
// while no result is stalled, with separate compare logic for the node, the
// parent, the prune limit and the top stem. Add makes one scan for the node
// and one for the parent. An undefined operation is taken and dropped without
// starting the sequencer.
// Reset clears the entry count, the sequencer and the output valid; the entry
// store is not cleared. A stalled result holds the sequencer in place until it
// is taken, except in the second scan for the add parent.
module tagged_stack_prune_table_unit
    import tspt_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 16,
    parameter int STEM_BITS = 8
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [15:0] node_id,
    input  logic [15:0] parent_id,
    input  logic        has_parent,
    input  logic        use_top,
    input  logic [7:0]  stem,
    input  logic        exact_match,
    input  logic        inclusive,
    input  logic [7:0]  nth,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        found,
    output logic [15:0] node_out,
    output logic [5:0]  position,
    output logic        last
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1; // search for node
    localparam logic [2:0] S_SCAN2 = 3'd2; // second search for add parent
    localparam logic [2:0] S_COMP  = 3'd3; // compaction
    localparam logic [2:0] S_TOP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5; // single result pending

    logic [2:0] state_reg, state_next;
    logic [ID_BITS-1:0]   ent_node   [DEPTH];
    logic [STEM_BITS-1:0] ent_stem   [DEPTH];
    logic [ID_BITS-1:0]   ent_parent [DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [2:0] func_reg;
    logic [ID_BITS-1:0] node_reg, par_reg;
    logic [STEM_BITS-1:0] stem_reg, limit_reg, limit_next;
    logic hp_reg, ex_reg, incl_reg, use_top_reg;
    logic [7:0] left_reg, left_next;
    logic held_reg, held_next;
    logic [15:0] held_node_reg, held_node_next;
    logic ov_reg, ov_next;
    logic [2:0] st_reg, st_next;
    logic fd_reg, fd_next, last_reg, last_next;
    logic [15:0] no_reg, no_next;
    logic [5:0] pos_reg, pos_next;

    logic [IW-1:0] ri;
    logic [IW-1:0] dn;
    logic rd_live, hit_node, hit_par, comp_kill, busy_out, top_hit_dn;
    logic do_move;
    logic [15:0] node_w;
    logic [15:0] node_dn;

    assign ri       = rd_reg[IW-1:0];
    assign rd_live  = rd_reg < count_reg;
    assign hit_node = ent_node[ri] == node_reg;
    assign hit_par  = ent_node[ri] == par_reg;
    assign comp_kill = ent_stem[ri] >= limit_reg;
    assign busy_out = ov_reg && out_stall;
    assign node_w = 16'(ent_node[ri]);

    // Top walks from the newest entry down; rd_reg counts the entries left.
    assign dn = IW'(rd_reg - 1'b1);
    assign top_hit_dn = ex_reg ? (ent_stem[dn] == stem_reg) : (ent_stem[dn] >= stem_reg);
    assign node_dn = 16'(ent_node[dn]);

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = ov_reg;
    assign status = st_reg; assign found = fd_reg; assign node_out = no_reg;
    assign position = pos_reg; assign last = last_reg;

    // The output register is loaded only when it is empty or being taken, so a
    // stalled transaction never changes. During compaction each removed node is
    // held back one step: it goes out when the next removal is found (last low)
    // or when the walk ends (last high), which marks the final one exactly.
    always_comb
    begin
        state_next = state_reg; count_next = count_reg; rd_next = rd_reg;
        wr_next = wr_reg; limit_next = limit_reg; left_next = left_reg;
        held_next = held_reg; held_node_next = held_node_reg;
        st_next = st_reg; fd_next = fd_reg;
        last_next = last_reg; no_next = no_reg; pos_next = pos_reg;
        do_move = 1'b0;
        ov_next = ov_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rd_next = '0; held_next = 1'b0;
                    left_next = nth;
                    limit_next = STEM_BITS'(stem);
                    case (func)
                        FUNC_ADD, FUNC_CHOP, FUNC_PARENT, FUNC_INDEX:
                            state_next = S_SCAN;
                        FUNC_PRUNE:
                        begin
                            state_next = S_COMP; wr_next = '0;
                        end
                        FUNC_TOP:
                        begin
                            state_next = S_TOP; rd_next = count_reg;
                        end
                        default: state_next = S_IDLE;
                    endcase
                    if (func == FUNC_CHOP && use_top)
                    begin
                        if (count_reg == '0)
                            rd_next = CW'(DEPTH);
                        else
                            rd_next = count_reg - 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (!busy_out)
                begin
                    if (func_reg == FUNC_CHOP && use_top_reg)
                    begin
                        if (rd_reg >= count_reg)
                            state_next = S_OUT;
                        else
                        begin
                            limit_next = ent_stem[ri];
                            rd_next = incl_reg ? rd_reg : rd_reg + 1'b1;
                            wr_next = rd_next;
                            state_next = S_COMP;
                        end
                        st_next = ST_OK; fd_next = 1'b0; no_next = '0;
                        pos_next = '0; last_next = 1'b1;
                    end
                    else if (rd_live && hit_node)
                    begin
                        st_next = ST_OK; fd_next = 1'b0; no_next = '0;
                        pos_next = '0; last_next = 1'b1;
                        case (func_reg)
                            FUNC_ADD:
                            begin
                                st_next = ST_DUP; state_next = S_OUT;
                            end
                            FUNC_CHOP:
                            begin
                                limit_next = ent_stem[ri];
                                rd_next = incl_reg ? rd_reg : rd_reg + 1'b1;
                                wr_next = rd_next;
                                state_next = S_COMP;
                            end
                            FUNC_PARENT:
                            begin
                                fd_next = rd_reg != '0;
                                no_next = (rd_reg != '0) ? 16'(ent_parent[ri]) : '0;
                                state_next = S_OUT;
                            end
                            default:
                            begin
                                fd_next = 1'b1; pos_next = 6'(rd_reg);
                                state_next = S_OUT;
                            end
                        endcase
                    end
                    else if (rd_live)
                        rd_next = rd_reg + 1'b1;
                    else
                    begin
                        st_next = ST_OK; fd_next = 1'b0; no_next = '0;
                        pos_next = '0; last_next = 1'b1; state_next = S_OUT;
                        if (func_reg == FUNC_ADD)
                        begin
                            if (count_reg == '0)
                                st_next = hp_reg ? ST_ROOT_PAR : ST_OK;
                            else if (!hp_reg)
                                st_next = ST_NULL_PAR;
                            else
                            begin
                                rd_next = '0; state_next = S_SCAN2;
                            end
                        end
                    end
                end
            end
            S_SCAN2:
            begin
                if (rd_live && hit_par)
                    state_next = S_OUT;
                else if (rd_live)
                    rd_next = rd_reg + 1'b1;
                else
                begin
                    st_next = ST_PAR_ABS; state_next = S_OUT;
                end
            end
            S_TOP:
            begin
                if (!busy_out)
                begin
                    st_next = ST_OK; pos_next = '0; last_next = 1'b1;
                    if (rd_reg == '0)
                    begin
                        fd_next = 1'b0; no_next = '0; state_next = S_OUT;
                    end
                    else
                    begin
                        rd_next = rd_reg - 1'b1;
                        if (top_hit_dn)
                        begin
                            if (left_reg == '0)
                            begin
                                fd_next = 1'b1; no_next = node_dn; state_next = S_OUT;
                            end
                            else
                                left_next = left_reg - 1'b1;
                        end
                    end
                end
            end
            S_COMP:
            begin
                if (!busy_out)
                begin
                    if (rd_live)
                    begin
                        rd_next = rd_reg + 1'b1;
                        if (comp_kill)
                        begin
                            held_next = 1'b1; held_node_next = node_w;
                            if (held_reg)
                            begin
                                ov_next = 1'b1; st_next = ST_OK; fd_next = 1'b1;
                                no_next = held_node_reg; pos_next = '0;
                                last_next = 1'b0;
                            end
                        end
                        else
                        begin
                            do_move = 1'b1; wr_next = wr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = wr_reg; state_next = S_IDLE;
                        ov_next = 1'b1; st_next = ST_OK; pos_next = '0;
                        last_next = 1'b1; fd_next = held_reg;
                        no_next = held_reg ? held_node_reg : '0;
                    end
                end
            end
            S_OUT:
            begin
                if (!busy_out)
                begin
                    ov_next = 1'b1; state_next = S_IDLE;
                    if (func_reg == FUNC_ADD && st_reg == ST_OK)
                    begin
                        if (count_reg >= CW'(DEPTH))
                            st_next = ST_FULL;
                        else
                            count_next = count_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_move)
        begin
            ent_node[wr_reg[IW-1:0]]   <= ent_node[ri];
            ent_stem[wr_reg[IW-1:0]]   <= ent_stem[ri];
            ent_parent[wr_reg[IW-1:0]] <= ent_parent[ri];
        end
        else if (state_reg == S_OUT && !busy_out && func_reg == FUNC_ADD
                 && st_reg == ST_OK && count_reg < CW'(DEPTH))
        begin
            ent_node[count_reg[IW-1:0]]   <= node_reg;
            ent_stem[count_reg[IW-1:0]]   <= stem_reg;
            ent_parent[count_reg[IW-1:0]] <= hp_reg ? par_reg : '0;
        end
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= func; node_reg <= ID_BITS'(node_id);
            par_reg <= ID_BITS'(parent_id); hp_reg <= has_parent;
            stem_reg <= STEM_BITS'(stem); ex_reg <= exact_match;
            incl_reg <= inclusive; use_top_reg <= use_top;
        end
        st_reg <= st_next; fd_reg <= fd_next; no_reg <= no_next;
        pos_reg <= pos_next; last_reg <= last_next;
        rd_reg <= rd_next; wr_reg <= wr_next; limit_reg <= limit_next;
        left_reg <= left_next; held_reg <= held_next;
        held_node_reg <= held_node_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; count_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; count_reg <= count_next; ov_reg <= ov_next;
        end
    end
endmodule

FILE: hdl/tspt_checker.sv
// Port-level checks for tagged_stack_prune_table_unit, bound to the top level.
// Depends on tspt_pkg and tagged_stack_prune_table_unit.
`timescale 1ns / 1ps
module tspt_checker
    import tspt_pkg::*;
(
    input logic clk, input logic rst_n,
    input logic in_valid, input logic in_stall, input logic [2:0] func,
    input logic out_valid, input logic out_stall,
    input logic found, input logic [15:0] node_out, input logic [5:0] position,
    input logic [2:0] status
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(node_out))
        else $error("stalled result changed");
    a_nf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> node_out == 16'd0 && position == 6'd0)
        else $error("empty result carries data");
    // Undefined operations are dropped at once, so only defined ones make it busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func <= FUNC_INDEX |=> in_stall)
        else $error("accepted while busy");
    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_FULL)
        else $error("bad status");
endmodule

bind tagged_stack_prune_table_unit tspt_checker u_chk (.*);
